// ===== sv/kaf_pkg.sv =====
package kaf_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned RegW  = 30;
	localparam int unsigned FracW = 30;
	localparam int unsigned IdxW  = 2;

	localparam logic [IdxW-1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [IdxW-1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [IdxW-1:0] REG_MEAS_NOISE  = 2'd2;
	localparam logic [IdxW-1:0] REG_TIME_STEP   = 2'd3;

	localparam logic [RegW-1:0] RST_ANGLE_NOISE = 30'd1073742;
	localparam logic [RegW-1:0] RST_BIAS_NOISE  = 30'd5368709;
	localparam logic [RegW-1:0] RST_MEAS_NOISE  = 30'd536870912;
	localparam logic [RegW-1:0] RST_TIME_STEP   = 30'd5368709;

	localparam logic signed [DataW-1:0] COV_ONE = 32'sd1073741824;

	// saturate a 36-bit signed value to 32 bits
	function automatic logic signed [DataW-1:0] sat36(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sd2147483647;
		lo = -36'sd2147483648;
		if (v > hi) begin
			sat36 = 32'sh7fffffff;
		end else if (v < lo) begin
			sat36 = 32'sh80000000;
		end else begin
			sat36 = v[DataW-1:0];
		end
	endfunction

endpackage

// ===== sv/kaf_mul.sv =====
// serial signed multiplier, one multiplier bit a cycle, result rounded by 2^30
// ties away from zero
module kaf_mul
	import kaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [35:0] a,
	input  logic signed [35:0] b,
	output logic               done,
	output logic signed [40:0] prod
);

	logic [71:0] acc_q;
	logic [35:0] mcand_q;
	logic [35:0] mplier_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [71:0] rnd;
	logic [71:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd36;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= a[35] ? 36'(-a) : a;
			mplier_q <= b[35] ? 36'(-b) : b;
			neg_q    <= a[35] ^ b[35];
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + ({36'd0, mcand_q} << (6'd36 - cnt_q));
			end
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = busy_q && (cnt_q == 6'd1) && !start;

	// final bit folded in combinationally at done
	always_comb begin
		rnd = acc_q;
		if (mplier_q[0]) begin
			rnd = acc_q + ({36'd0, mcand_q} << 6'd35);
		end
		shifted = (rnd + 72'(1 << (FracW - 1))) >> FracW;
		prod = neg_q ? -$signed(shifted[40:0]) : $signed(shifted[40:0]);
	end

endmodule

// ===== sv/kaf_div.sv =====
// restoring divider, one quotient bit a cycle: q = trunc(n * 2^30 / d), saturated
module kaf_div
	import kaf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [35:0]       num,
	input  logic [35:0]              den,
	output logic                     done,
	output logic signed [DataW-1:0]  quot
);

	logic [65:0] rem_q;
	logic [65:0] dvd_q;
	logic [35:0] den_q;
	logic [66:0] q_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [66:0] trial;
	logic signed [35:0] qs;

	// done_q rises in the same cycle that the last quotient bit lands in q_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd66;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign trial = {rem_q, dvd_q[65]} - {31'd0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {(num[35] ? 36'(-num) : num), 30'd0};
			den_q <= den;
			q_q   <= '0;
			neg_q <= num[35];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!trial[66]) begin
				rem_q <= trial[65:0];
				q_q   <= {q_q[65:0], 1'b1};
			end else begin
				rem_q <= {rem_q[64:0], dvd_q[65]};
				q_q   <= {q_q[65:0], 1'b0};
			end
		end
	end

	assign done = done_q;

	always_comb begin
		if (q_q[66:34] != '0) begin
			qs = neg_q ? -36'sd2147483649 : 36'sd2147483648;
		end else begin
			qs = neg_q ? -$signed({2'b00, q_q[33:0]}) : $signed({2'b00, q_q[33:0]});
		end
		quot = sat36(qs);
	end

endmodule

// ===== sv/kalman_angle_filter.sv =====
// two-state angle/gyro-bias kalman filter, one word in, one word out
// from input accept to out_valid: 10 serial multiplies and 2 serial divides,
// then the finished word is loaded into the output register
// a new word is taken only once the last has moved to the output; a result may wait while the next is taken
// reset: registers take their default noise and time step, angle and bias
// clear, covariance returns to identity
module kalman_angle_filter
	import kaf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [kaf_pkg::IdxW-1:0] cfg_index,
	input  logic [kaf_pkg::RegW-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      measured_angle,
	input  logic signed [31:0]      gyro_rate,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      angle_estimate_out,
	output logic signed [31:0]      rate_estimate_out
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_MWT  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_DWT  = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_HOLD = 7'b1000000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;

	// config registers
	logic [RegW-1:0] qa_q, qb_q, rm_q, dt_q;

	// filter state
	logic signed [31:0] ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
	// per-word working values
	logic signed [31:0] meas_q, gyro_q, pred_q, a00_q, a01_q, a10_q, a11_q, k0_q, k1_q;
	logic signed [35:0] err_q;

	// shared serial multiplier and divider
	logic               mul_go, mul_done;
	logic signed [35:0] mul_a, mul_b;
	logic signed [40:0] mul_p;
	logic               div_go;
	logic signed [35:0] div_n;
	logic [35:0]        div_d;
	logic signed [31:0] div_qt;
	logic               div_done;
	logic signed [35:0] e_val;

	kaf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	kaf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_n), .den(div_d),
		.done(div_done), .quot(div_qt)
	);

	// output skid: result word held here while the next sample runs
	logic               ovld_q;
	logic signed [31:0] oang_q, orate_q;
	logic               out_load;

	assign in_stall            = (state_q != ST_IDLE);
	assign out_valid           = ovld_q;
	assign angle_estimate_out  = oang_q;
	assign rate_estimate_out   = orate_q;

	// finished word moves to the output when the register is free or being taken
	assign out_load = (state_q == ST_OUT) && (!ovld_q || !out_stall);

	assign e_val = 36'($signed({1'b0, rm_q})) + 36'(a00_q);

	// operand select per multiply step
	always_comb begin
		mul_a = '0;
		mul_b = 36'($signed({1'b0, dt_q}));
		case (step_q)
			5'd0: mul_a = 36'(gyro_q) - 36'(bias_q);
			5'd1: mul_a = 36'($signed({1'b0, qa_q})) - 36'(pab_q) - 36'(pba_q);
			5'd2: mul_a = 36'(pbb_q);
			5'd3: mul_a = 36'($signed({1'b0, qb_q}));
			5'd4: begin mul_a = 36'(k0_q); mul_b = 36'(a00_q); end
			5'd5: begin mul_a = 36'(k0_q); mul_b = 36'(a01_q); end
			5'd6: begin mul_a = 36'(k1_q); mul_b = 36'(a00_q); end
			5'd7: begin mul_a = 36'(k1_q); mul_b = 36'(a01_q); end
			5'd8: begin mul_a = 36'(k0_q); mul_b = err_q; end
			5'd9: begin mul_a = 36'(k1_q); mul_b = err_q; end
			default: mul_a = '0;
		endcase
		div_n = (step_q == 5'd0) ? 36'(a00_q) : 36'(a10_q);
		div_d = e_val;
	end

	assign mul_go = (state_q == ST_MUL);
	assign div_go = (state_q == ST_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= RST_ANGLE_NOISE;
			qb_q <= RST_BIAS_NOISE;
			rm_q <= RST_MEAS_NOISE;
			dt_q <= RST_TIME_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_NOISE: qa_q <= cfg_data;
				REG_BIAS_NOISE:  qb_q <= cfg_data;
				REG_MEAS_NOISE:  rm_q <= cfg_data;
				REG_TIME_STEP:   dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (out_load) begin
			ovld_q <= 1'b1;
		end else if (!out_stall) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oang_q  <= ang_q;
			orate_q <= sat36(36'(gyro_q) - 36'(bias_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ang_q   <= '0;
			bias_q  <= '0;
			paa_q   <= COV_ONE;
			pab_q   <= '0;
			pba_q   <= '0;
			pbb_q   <= COV_ONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						meas_q  <= measured_angle;
						gyro_q  <= gyro_rate;
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_MWT;
				ST_MWT: begin
					if (mul_done) begin
						case (step_q)
							5'd0: begin
								pred_q <= sat36(36'(ang_q) + mul_p[35:0]);
								err_q  <= 36'(meas_q) - 36'(sat36(36'(ang_q) + mul_p[35:0]));
							end
							5'd1: a00_q <= sat36(36'(paa_q) + mul_p[35:0]);
							5'd2: begin
								a01_q <= sat36(36'(pab_q) - mul_p[35:0]);
								a10_q <= sat36(36'(pba_q) - mul_p[35:0]);
							end
							5'd3: a11_q <= sat36(36'(pbb_q) + mul_p[35:0]);
							5'd4: paa_q <= sat36(36'(a00_q) - mul_p[35:0]);
							5'd5: pab_q <= sat36(36'(a01_q) - mul_p[35:0]);
							5'd6: pba_q <= sat36(36'(a10_q) - mul_p[35:0]);
							5'd7: pbb_q <= sat36(36'(a11_q) - mul_p[35:0]);
							5'd8: ang_q <= sat36(36'(pred_q) + mul_p[35:0]);
							5'd9: bias_q <= sat36(36'(bias_q) + mul_p[35:0]);
							default: ;
						endcase
						// prediction done: go form the gains; last correction: emit
						if (step_q == 5'd3) begin
							step_q  <= '0;
							state_q <= ST_DIV;
						end else if (step_q == 5'd9) begin
							state_q <= ST_OUT;
						end else if (step_q > 5'd9) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV: state_q <= ST_DWT;
				ST_DWT: begin
					if (div_done) begin
						if (step_q == 5'd0) begin
							k0_q    <= (e_val > 0) ? div_qt : '0;
							step_q  <= 5'd1;
							state_q <= ST_DIV;
						end else begin
							k1_q    <= (e_val > 0) ? div_qt : '0;
							step_q  <= 5'd4;
							state_q <= ST_MUL;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HOLD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
